// ===== rtl/core/max_falling_path_sum_defines.svh =====
// assertion macros shared by the checker of the falling path sum block
`ifndef MAX_FALLING_PATH_SUM_DEFINES_SVH
`define MAX_FALLING_PATH_SUM_DEFINES_SVH

// implication checked in the same cycle, ignored while in reset
`define MFPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent, also active during reset
`define MFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mfps_pkg.sv =====
// shared constants, types and size helpers of the falling path sum block
package mfps_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 256;

  localparam int CELL_W     = 16;
  localparam int SUM_W      = 26;
  localparam int BEST_W     = SUM_W + 1;
  localparam int ROW_CFG_W  = 11;
  localparam int COL_CFG_W  = 9;
  localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = ROW_CFG_W;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

  // saturation bounds of a path sum and the reset value of the best sum
  localparam logic signed [SUM_W-1:0]  SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [BEST_W-1:0] BEST_RESET = {1'b1, {(BEST_W-1){1'b0}}};

  // control handed from the datapath to the row of cells
  typedef struct packed {
    logic                    shift;
    logic [COL_IDX_W-1:0]    tail;
    logic signed [SUM_W-1:0] new_sum;
  } chain_ctl_t;

  // last column index for a written column count (zero acts as one, oversized clamps)
  function automatic logic [COL_IDX_W-1:0] cols_last_f(input logic [COL_CFG_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (v > COL_CFG_W'(MAX_COLS)) begin
      return COL_IDX_W'(MAX_COLS - 1);
    end else begin
      return COL_IDX_W'(v - 1'b1);
    end
  endfunction

  // last row index for a written row count (zero acts as one, oversized clamps)
  function automatic logic [ROW_IDX_W-1:0] rows_last_f(input logic [ROW_CFG_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (v > ROW_CFG_W'(MAX_ROWS)) begin
      return ROW_IDX_W'(MAX_ROWS - 1);
    end else begin
      return ROW_IDX_W'(v - 1'b1);
    end
  endfunction

endpackage

// ===== rtl/core/mfps_if.sv =====
// channel interfaces: cell input, result output and configuration writes
interface mfps_in_if;
  import mfps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface mfps_out_if;
  import mfps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] best_sum;
  modport source (output valid, output best_sum, input ready);
  modport sink (input valid, input best_sum, output ready);
endinterface

interface mfps_cfg_if;
  import mfps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mfps_cell.sv =====
// one cell of the row: holds one previous-row path sum
module mfps_cell (
  input  logic                             clk,
  input  logic [mfps_pkg::COL_IDX_W-1:0]   cell_idx,
  input  mfps_pkg::chain_ctl_t             ctl,
  input  logic signed [mfps_pkg::SUM_W-1:0] next_val,
  output logic signed [mfps_pkg::SUM_W-1:0] val
);
  import mfps_pkg::*;

  logic signed [SUM_W-1:0] val_r;
  logic signed [SUM_W-1:0] val_nxt;

  // tail cell takes the fresh sum, the others take their neighbor
  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = (cell_idx == ctl.tail) ? ctl.new_sum : next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== rtl/core/mfps_row_chain.sv =====
// rotating row of cells; head holds the sum straight up, next one the right diagonal
module mfps_row_chain (
  input  logic                              clk,
  input  mfps_pkg::chain_ctl_t              ctl,
  output logic signed [mfps_pkg::SUM_W-1:0] up_sum,
  output logic signed [mfps_pkg::SUM_W-1:0] right_sum
);
  import mfps_pkg::*;

  logic signed [SUM_W-1:0] cell_val [MAX_COLS];

  // each cell hands its value to the one in front of it
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    logic signed [SUM_W-1:0] nb;
    if (k == MAX_COLS - 1) begin : g_end
      assign nb = cell_val[k];
    end else begin : g_mid
      assign nb = cell_val[k+1];
    end
    mfps_cell u_cell (
      .clk      (clk),
      .cell_idx (COL_IDX_W'(k)),
      .ctl      (ctl),
      .next_val (nb),
      .val      (cell_val[k])
    );
  end

  assign up_sum = cell_val[0];

  if (MAX_COLS > 1) begin : g_right
    assign right_sum = cell_val[1];
  end else begin : g_no_right
    assign right_sum = cell_val[0];
  end

endmodule

// ===== rtl/core/max_falling_path_sum.sv =====
// max_falling_path_sum: one cell per cycle unless a final cell waits on the output.
// best_sum is registered and valid in the cycle after the transfer of the last cell.
// Throughput: 1 cell per unstalled cycle; the sum fed back through the head of the
//   row of cells and the max/add/saturate step sets the cycle.
// Reset (rst_n low, synchronous): sizes 1 x 1, indices cleared, no result pending.
module max_falling_path_sum (
  input logic       clk,
  input logic       rst_n,
  mfps_in_if.sink   in_if,
  mfps_out_if.source out_if,
  mfps_cfg_if.sink  cfg_if
);
  import mfps_pkg::*;

  logic [ROW_IDX_W-1:0]     rows_last_r, rows_last_nxt;
  logic [COL_IDX_W-1:0]     cols_last_r, cols_last_nxt;
  logic [ROW_IDX_W-1:0]     row_r, row_nxt;
  logic [COL_IDX_W-1:0]     col_r, col_nxt;
  logic signed [SUM_W-1:0]  left_r, left_nxt;
  logic signed [BEST_W-1:0] best_r, best_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]  out_sum_r, out_sum_nxt;

  logic                     in_xfer, cfg_xfer, cfg_hit;
  logic                     first_row, last_row, last_col, has_left, has_right;
  logic signed [SUM_W-1:0]  up_sum, right_sum, best_above, sum;
  logic signed [BEST_W-1:0] raw_sum, cand;
  chain_ctl_t               ctl;

  // position flags
  assign first_row = (row_r == '0);
  assign last_row  = (row_r == rows_last_r);
  assign last_col  = (col_r == cols_last_r);
  assign has_left  = (col_r != '0);
  assign has_right = !last_col;

  // a final cell needs a free output slot, any other cell goes straight in
  assign in_if.ready = !out_valid_r || out_if.ready || !(last_row && last_col);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_xfer    = cfg_if.valid;

  // best of the neighbors above
  always_comb begin
    best_above = up_sum;
    if (has_left && (left_r > best_above)) begin
      best_above = left_r;
    end
    if (has_right && (right_sum > best_above)) begin
      best_above = right_sum;
    end
  end

  // add and saturate to the sum range
  assign raw_sum = BEST_W'(in_if.cell_value) + BEST_W'(best_above);
  always_comb begin
    if (first_row) begin
      sum = SUM_W'(in_if.cell_value);
    end else if (raw_sum[BEST_W-1] != raw_sum[BEST_W-2]) begin
      sum = raw_sum[BEST_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum = raw_sum[SUM_W-1:0];
    end
  end

  assign cand = (BEST_W'(sum) > best_r) ? BEST_W'(sum) : best_r;

  // row of cells
  assign ctl.shift   = in_xfer;
  assign ctl.tail    = cols_last_r;
  assign ctl.new_sum = sum;

  mfps_row_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .up_sum    (up_sum),
    .right_sum (right_sum)
  );

  // configuration decode
  always_comb begin
    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    cfg_hit       = 1'b0;
    if (cfg_xfer) begin
      unique case (cfg_if.index)
        REG_ROW_COUNT: begin
          rows_last_nxt = rows_last_f(cfg_if.data[ROW_CFG_W-1:0]);
          cfg_hit       = 1'b1;
        end
        REG_COLUMN_COUNT: begin
          cols_last_nxt = cols_last_f(cfg_if.data[COL_CFG_W-1:0]);
          cfg_hit       = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // walk through the matrix and track the last-row best
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    left_nxt      = left_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_sum_nxt   = out_sum_r;
    if (in_xfer) begin
      left_nxt = last_col ? '0 : up_sum;
      if (last_row) begin
        best_nxt = cand;
      end
      if (!last_col) begin
        col_nxt = col_r + 1'b1;
      end else begin
        col_nxt = '0;
        if (!last_row) begin
          row_nxt = row_r + 1'b1;
        end else begin
          row_nxt       = '0;
          best_nxt      = BEST_RESET;
          out_valid_nxt = 1'b1;
          out_sum_nxt   = cand[SUM_W-1:0];
        end
      end
    end
    if (cfg_hit) begin
      row_nxt  = '0;
      col_nxt  = '0;
      left_nxt = '0;
      best_nxt = BEST_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= '0;
      cols_last_r <= '0;
      row_r       <= '0;
      col_r       <= '0;
      left_r      <= '0;
      best_r      <= BEST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      rows_last_r <= rows_last_nxt;
      cols_last_r <= cols_last_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      left_r      <= left_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.best_sum = out_sum_r;

endmodule

// ===== rtl/core/mfps_checker.sv =====
// port-level checks of the falling path sum block and their binding
`include "max_falling_path_sum_defines.svh"

module mfps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mfps_pkg::SUM_W-1:0] best_sum
);
  import mfps_pkg::*;

  // a stalled result keeps its value
  `MFPS_ASSERT_NEXT(a_out_hold, rst_n && out_valid && !out_ready, !rst_n || (out_valid && $stable(best_sum)), "stalled result changed")

  // reset leaves no result pending
  `MFPS_ASSERT_NEXT(a_rst_clear, !rst_n, !out_valid, "result pending after reset")

  // a result only appears after a cell transfer
  `MFPS_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_valid && in_ready), "result without cell transfer")

  // input stays open while no result is pending
  `MFPS_ASSERT_NOW(a_in_open, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind max_falling_path_sum mfps_checker u_mfps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .best_sum  (out_if.best_sum)
);

// ===== tb/sv/tb_max_falling_path_sum.sv =====
// testbench of max_falling_path_sum: streamed matrices checked against a path sum predictor
module tb_max_falling_path_sum;
  timeunit 1ns;
  timeprecision 1ps;

  import mfps_pkg::*;

  localparam int RANDOM_CELLS  = 670;
  localparam int MAX_IDLE      = 14;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 5000;

  // indexes past the register list, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_COLUMN_COUNT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = {CFG_IDX_W{1'b1}};

  localparam logic signed [BEST_W-1:0] SAT_HI = BEST_W'(SUM_MAX);
  localparam logic signed [BEST_W-1:0] SAT_LO = BEST_W'(SUM_MIN);

  typedef enum logic [1:0] {STEP_WRITE, STEP_CELLS} step_kind_t;

  // one row of the directed table: a register write, or count cells of one value
  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    int                   arg;
    int                   count;
    bit                   typed;
    int                   want;
  } dir_step_t;

  localparam dir_step_t DIRECTED_STEPS [38] = '{
    // sizes 1 x 1 after reset, every cell is its own result
    '{STEP_CELLS, REG_ROW_COUNT, 32767, 1, 1'b1, 32767},
    '{STEP_CELLS, REG_ROW_COUNT, -32768, 1, 1'b1, -32768},
    '{STEP_CELLS, REG_ROW_COUNT, 0, 1, 1'b1, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -1, 1, 1'b1, -1},
    // zero sizes act as one
    '{STEP_WRITE, REG_ROW_COUNT, 0, 0, 1'b0, 0},
    '{STEP_WRITE, REG_COLUMN_COUNT, 0, 0, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 12345, 1, 1'b1, 12345},
    // 2 x 3 matrix, edge columns see two neighbors only
    '{STEP_WRITE, REG_ROW_COUNT, 2, 0, 1'b0, 0},
    '{STEP_WRITE, REG_COLUMN_COUNT, 3, 0, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 1, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -5, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 7, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 2, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 0, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -3, 1, 1'b0, 0},
    // partial matrix dropped by a register write
    '{STEP_WRITE, REG_COLUMN_COUNT, 2, 0, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 100, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 200, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 300, 1, 1'b0, 0},
    '{STEP_WRITE, REG_COLUMN_COUNT, 2, 0, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -1, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -2, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -3, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -4, 1, 1'b0, 0},
    // writes past the register list, then column data with high bits set
    '{STEP_WRITE, REG_SPARE, 5, 0, 1'b0, 0},
    '{STEP_WRITE, REG_TOP, 2047, 0, 1'b0, 0},
    '{STEP_WRITE, REG_COLUMN_COUNT, 'h602, 0, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 9, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -9, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 32767, 1, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -32768, 1, 1'b0, 0},
    // tall column of extreme cells builds large sums
    '{STEP_WRITE, REG_ROW_COUNT, 32, 0, 1'b0, 0},
    '{STEP_WRITE, REG_COLUMN_COUNT, 1, 0, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 32767, 32, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, -32768, 32, 1'b0, 0},
    // widest row, oversized column count clamps
    '{STEP_WRITE, REG_ROW_COUNT, 1, 0, 1'b0, 0},
    '{STEP_WRITE, REG_COLUMN_COUNT, 511, 0, 1'b0, 0},
    '{STEP_CELLS, REG_ROW_COUNT, 5, 256, 1'b1, 5}
  };

  logic clk;
  logic rst_n;

  mfps_in_if  cell_ch ();
  mfps_out_if sum_ch ();
  mfps_cfg_if cfg_ch ();

  max_falling_path_sum uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cell_ch),
    .out_if (sum_ch),
    .cfg_if (cfg_ch)
  );

  // predictor state
  logic [ROW_CFG_W-1:0]     rows_reg;
  logic [COL_CFG_W-1:0]     cols_reg;
  logic signed [BEST_W-1:0] path_sum [MAX_COLS];
  logic signed [BEST_W-1:0] left_above;
  logic signed [BEST_W-1:0] best_so_far;
  int                       col_at;
  int                       row_at;

  logic signed [SUM_W-1:0] best_sums_due [$];
  logic signed [SUM_W-1:0] due_sum;
  int                      sum_errors = 0;
  bit                      gaps_on = 1'b1;
  bit                      hold_request = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int eff_size(input int v, input int limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  function automatic void clear_progress();
    left_above  = '0;
    col_at      = 0;
    row_at      = 0;
    best_so_far = BEST_RESET;
  endfunction

  // one cell through the path sum recurrence, flags the end of a matrix
  function automatic void take_cell(input logic signed [CELL_W-1:0] v, output bit emits,
                                    output logic signed [SUM_W-1:0] best);
    int rows;
    int cols;
    int j;
    logic signed [BEST_W-1:0] above;
    logic signed [BEST_W-1:0] s;
    bit last_row;
    rows = eff_size(int'(rows_reg), MAX_ROWS);
    cols = eff_size(int'(cols_reg), MAX_COLS);
    j = (col_at >= cols) ? cols - 1 : col_at;
    if (row_at >= rows) row_at = rows - 1;
    if (row_at == 0) begin
      s = BEST_W'(v);
    end else begin
      above = path_sum[j];
      if (j > 0 && left_above > above) above = left_above;
      if (j + 1 < cols && path_sum[j + 1] > above) above = path_sum[j + 1];
      s = above + BEST_W'(v);
      if (s > SAT_HI) s = SAT_HI;
      else if (s < SAT_LO) s = SAT_LO;
    end
    left_above  = path_sum[j];
    path_sum[j] = s;
    last_row = (row_at + 1 == rows);
    if (last_row && s > best_so_far) best_so_far = s;
    emits = 1'b0;
    best  = '0;
    if (j + 1 < cols) begin
      col_at = j + 1;
    end else begin
      col_at     = 0;
      left_above = '0;
      if (!last_row) begin
        row_at++;
      end else begin
        emits = 1'b1;
        best  = best_so_far[SUM_W-1:0];
        clear_progress();
      end
    end
  endfunction

  // offer one cell after a random gap, predict on its transfer
  task automatic send_cell(input logic signed [CELL_W-1:0] v, input bit typed,
                           input logic signed [SUM_W-1:0] want);
    int gap;
    bit emits;
    logic signed [SUM_W-1:0] pred;
    gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cell_ch.valid      <= 1'b1;
    cell_ch.cell_value <= v;
    do @(posedge clk); while (!(cell_ch.valid && cell_ch.ready));
    take_cell(v, emits, pred);
    if (emits) best_sums_due.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // hold the input until every pending sum has come out, then let the block go quiet
  task automatic settle();
    cell_ch.valid <= 1'b0;
    while (best_sums_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (idx == REG_ROW_COUNT) begin
      rows_reg = val;
      clear_progress();
    end else if (idx == REG_COLUMN_COUNT) begin
      cols_reg = val[COL_CFG_W-1:0];
      clear_progress();
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stall per transfer, one long hold-off on request
  initial begin
    int stall;
    sum_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        sum_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      sum_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(sum_ch.valid && sum_ch.ready) && !hold_request) @(posedge clk);
      @(negedge clk);
    end
  end

  // compare each result transfer with the oldest pending sum
  always @(posedge clk) begin
    if (rst_n && sum_ch.valid && sum_ch.ready) begin
      if (best_sums_due.size() == 0) begin
        $display("%0t: best_sum expected none, got %0d", $time, sum_ch.best_sum);
        sum_errors++;
      end else begin
        due_sum = best_sums_due.pop_front();
        if (sum_ch.best_sum !== due_sum) begin
          $display("%0t: best_sum expected %0d, got %0d", $time, due_sum, sum_ch.best_sum);
          sum_errors++;
        end
      end
    end
  end

  // stimulus: directed table, pressure, then random matrices
  initial begin
    dir_step_t step;
    int random_cells;
    int rows_pick;
    int cols_pick;
    int cells_per;
    int n_mat;
    int n;
    int wait_cnt;
    logic signed [CELL_W-1:0] cell_pick;

    rst_n              = 1'b0;
    cell_ch.valid      = 1'b0;
    cell_ch.cell_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    rows_reg           = ROW_CFG_W'(1);
    cols_reg           = COL_CFG_W'(1);
    foreach (path_sum[i]) path_sum[i] = '0;
    clear_progress();
    random_cells = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_STEPS[i]) begin
      step = DIRECTED_STEPS[i];
      if (step.kind == STEP_WRITE) begin
        write_reg(step.reg_idx, CFG_DATA_W'(step.arg));
      end else begin
        repeat (step.count) send_cell(CELL_W'(step.arg), step.typed, SUM_W'(step.want));
      end
    end

    // back-to-back 1 x 1 matrices against a long result stall
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(1));
    write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(1));
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_cell(CELL_W'($urandom), 1'b0, '0);
    settle();
    gaps_on = 1'b1;

    while (random_cells < RANDOM_CELLS) begin
      gaps_on   = ($urandom_range(0, 4) != 0);
      rows_pick = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) rows_pick = $urandom_range(7, 24);
      cols_pick = $urandom_range(0, 9);
      if ($urandom_range(0, 24) == 0) begin
        cols_pick = $urandom_range(MAX_COLS + 1, (1 << COL_CFG_W) - 1);
        rows_pick = $urandom_range(1, 2);
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE), int'(REG_TOP))),
                  CFG_DATA_W'($urandom));
      end
      write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows_pick));
      write_reg(REG_COLUMN_COUNT,
                CFG_DATA_W'(cols_pick | ($urandom_range(0, 3) << COL_CFG_W)));
      cells_per = eff_size(rows_pick, MAX_ROWS) * eff_size(cols_pick, MAX_COLS);
      n_mat = $urandom_range(1, 3);
      for (int m = 0; m < n_mat; m++) begin
        n = cells_per;
        // broken matrix, cut short by the next register write
        if (m == n_mat - 1 && $urandom_range(0, 7) == 0) n = $urandom_range(0, cells_per - 1);
        for (int k = 0; k < n && random_cells < RANDOM_CELLS; k++) begin
          if ($urandom_range(0, 30) == 0) settle();
          case ($urandom_range(0, 5))
            0: cell_pick = CELL_W'(int'($urandom_range(0, 15)) - 8);
            1: cell_pick = $urandom_range(0, 1) ? CELL_W'(32767) : CELL_W'(-32768);
            default: cell_pick = CELL_W'($urandom);
          endcase
          send_cell(cell_pick, 1'b0, '0);
          random_cells++;
        end
      end
    end

    // drain with a bound, then the verdict
    cell_ch.valid <= 1'b0;
    for (wait_cnt = 0; wait_cnt < DRAIN_LIMIT && best_sums_due.size() != 0; wait_cnt++) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (best_sums_due.size() != 0) begin
      $display("%0t: %0d best sums never arrived", $time, best_sums_due.size());
      sum_errors++;
    end
    if (sum_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== max_falling_path_sum.f =====
+incdir+rtl/core
rtl/core/mfps_pkg.sv
rtl/core/mfps_if.sv
rtl/core/mfps_cell.sv
rtl/core/mfps_row_chain.sv
rtl/core/max_falling_path_sum.sv
rtl/core/mfps_checker.sv
tb/sv/tb_max_falling_path_sum.sv
